// ----- rtl/mim_pkg.sv -----
package mim_pkg;

    // Residues and matrix entries share one word width
    localparam int WORD_BITS  = 8;
    localparam int ENTRY_BITS = 8;
    localparam int MOD_BITS   = 9;
    localparam int BIT_CNT_W  = $clog2(WORD_BITS);
    localparam int PC_W       = 5;

    localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(26);
    localparam logic [MOD_BITS-1:0] MOD_MIN   = MOD_BITS'(2);
    localparam logic [MOD_BITS-1:0] MOD_MAX   = MOD_BITS'(256);

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,    // take one input beat into A..D
        OP_RED,     // dst = src_x mod m, one bit per cycle
        OP_MUL,     // dst = src_x * src_y mod m, one bit of src_y per cycle
        OP_SUBM,    // dst = (src_x - src_y) mod m
        OP_NEG,     // dst = (-src_x) mod m
        OP_SINIT,   // K = 1, T = DET
        OP_SRCH,    // one step of the inverse search
        OP_DONE,    // publish the inverse
        OP_FAIL     // publish a non-invertible result
    } op_t;

    // Working registers
    typedef enum logic [2:0] {
        SEL_A,
        SEL_B,
        SEL_C,
        SEL_D,
        SEL_DET,
        SEL_K,
        SEL_T
    } sel_t;

    // Condition that moves the step counter on
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_BEAT,
        COND_ITER_LAST,
        COND_FOUND,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t              op;
        sel_t             dst;
        sel_t             src_x;
        sel_t             src_y;
        cond_t            cond;
        logic             branch;   // go to target when the search runs out
        logic             jump;     // go to target instead of the next step
        logic [PC_W-1:0]  target;
    } cw_t;

    typedef struct packed {
        cw_t                   cw;
        logic [BIT_CNT_W-1:0]  bit_cnt;
        logic                  last;
    } ctl_t;

    typedef struct packed {
        logic in_beat;
        logic found;
        logic exhausted;
        logic out_free;
    } stat_t;

    localparam logic [PC_W-1:0] PC_START = PC_W'(0);
    localparam logic [PC_W-1:0] PC_FAIL  = PC_W'(17);

    function automatic cw_t uc(op_t op, sel_t dst, sel_t sx, sel_t sy, cond_t cond,
                               logic branch, logic jump, logic [PC_W-1:0] target);
        cw_t w;
        w.op     = op;
        w.dst    = dst;
        w.src_x  = sx;
        w.src_y  = sy;
        w.cond   = cond;
        w.branch = branch;
        w.jump   = jump;
        w.target = target;
        return w;
    endfunction

    // Microprogram
    function automatic cw_t ucode_rom(logic [PC_W-1:0] pc);
        cw_t w;
        unique case (pc)
            PC_W'(0):  w = uc(OP_LOAD,  SEL_A,   SEL_A,   SEL_A, COND_IN_BEAT,   1'b0, 1'b0,
                              PC_START);
            PC_W'(1):  w = uc(OP_RED,   SEL_A,   SEL_A,   SEL_A, COND_ITER_LAST, 1'b0, 1'b0,
                              PC_START);
            PC_W'(2):  w = uc(OP_RED,   SEL_B,   SEL_B,   SEL_B, COND_ITER_LAST, 1'b0, 1'b0,
                              PC_START);
            PC_W'(3):  w = uc(OP_RED,   SEL_C,   SEL_C,   SEL_C, COND_ITER_LAST, 1'b0, 1'b0,
                              PC_START);
            PC_W'(4):  w = uc(OP_RED,   SEL_D,   SEL_D,   SEL_D, COND_ITER_LAST, 1'b0, 1'b0,
                              PC_START);
            PC_W'(5):  w = uc(OP_MUL,   SEL_T,   SEL_A,   SEL_D, COND_ITER_LAST, 1'b0, 1'b0,
                              PC_START);
            PC_W'(6):  w = uc(OP_MUL,   SEL_DET, SEL_B,   SEL_C, COND_ITER_LAST, 1'b0, 1'b0,
                              PC_START);
            PC_W'(7):  w = uc(OP_SUBM,  SEL_DET, SEL_T,   SEL_DET, COND_ALWAYS,  1'b0, 1'b0,
                              PC_START);
            PC_W'(8):  w = uc(OP_SINIT, SEL_K,   SEL_DET, SEL_K, COND_ALWAYS,    1'b0, 1'b0,
                              PC_START);
            PC_W'(9):  w = uc(OP_SRCH,  SEL_K,   SEL_DET, SEL_K, COND_FOUND,     1'b1, 1'b0,
                              PC_FAIL);
            PC_W'(10): w = uc(OP_NEG,   SEL_B,   SEL_B,   SEL_B, COND_ALWAYS,    1'b0, 1'b0,
                              PC_START);
            PC_W'(11): w = uc(OP_NEG,   SEL_C,   SEL_C,   SEL_C, COND_ALWAYS,    1'b0, 1'b0,
                              PC_START);
            PC_W'(12): w = uc(OP_MUL,   SEL_D,   SEL_D,   SEL_K, COND_ITER_LAST, 1'b0, 1'b0,
                              PC_START);
            PC_W'(13): w = uc(OP_MUL,   SEL_B,   SEL_B,   SEL_K, COND_ITER_LAST, 1'b0, 1'b0,
                              PC_START);
            PC_W'(14): w = uc(OP_MUL,   SEL_C,   SEL_C,   SEL_K, COND_ITER_LAST, 1'b0, 1'b0,
                              PC_START);
            PC_W'(15): w = uc(OP_MUL,   SEL_A,   SEL_A,   SEL_K, COND_ITER_LAST, 1'b0, 1'b0,
                              PC_START);
            PC_W'(16): w = uc(OP_DONE,  SEL_A,   SEL_A,   SEL_A, COND_OUT_FREE,  1'b0, 1'b1,
                              PC_START);
            PC_W'(17): w = uc(OP_FAIL,  SEL_A,   SEL_A,   SEL_A, COND_OUT_FREE,  1'b0, 1'b1,
                              PC_START);
            default:   w = uc(OP_NOP,   SEL_A,   SEL_A,   SEL_A, COND_ALWAYS,    1'b0, 1'b1,
                              PC_START);
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/matrix_inverse_2x2_mod_top.sv -----
// 2x2 key matrix inverse modulo a programmable modulus (Hill cipher key setup).
// Input channel: in_valid/in_ready, one beat carries the four matrix entries.
// Output channel: out_valid/out_ready, one beat carries the invertible flag,
// the determinant residue and the four inverse entries (zero if not invertible).
// Config: cfg_wr_en/cfg_wr_data write the modulus (reset 26; 0..1 act as 2,
// values above 256 act as 256). Write it only while no matrix is in flight.
// A microprogram steps a small modular datapath: four bit-serial reductions,
// two modular multiplies and a subtraction for the determinant, a linear
// search for the determinant inverse (one candidate per cycle), then two
// negations and four multiplies by that inverse. One matrix is worked on
// at a time, so a new input beat is taken only once the previous result has
// been handed to the output register; in_ready is high only while waiting for
// input. The result sits in an output register, so the next matrix is taken
// while a result still waits; a stalled receiver holds the block only once
// the following result is ready. Reset empties the output and returns the
// sequencer to waiting for input.
module matrix_inverse_2x2_mod_top
    import mim_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [MOD_BITS-1:0]    cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ENTRY_BITS-1:0]  entry_top_left,
    input  logic [ENTRY_BITS-1:0]  entry_top_right,
    input  logic [ENTRY_BITS-1:0]  entry_bottom_left,
    input  logic [ENTRY_BITS-1:0]  entry_bottom_right,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   invertible,
    output logic [WORD_BITS-1:0]   det_residue,
    output logic [WORD_BITS-1:0]   inv_top_left,
    output logic [WORD_BITS-1:0]   inv_top_right,
    output logic [WORD_BITS-1:0]   inv_bottom_left,
    output logic [WORD_BITS-1:0]   inv_bottom_right
);

    ctl_t   ctl;
    stat_t  stat;

    // Step counter and microcode ROM
    mim_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // Modular datapath and channel registers
    mim_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .stat               (stat),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .entry_top_left     (entry_top_left),
        .entry_top_right    (entry_top_right),
        .entry_bottom_left  (entry_bottom_left),
        .entry_bottom_right (entry_bottom_right),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .invertible         (invertible),
        .det_residue        (det_residue),
        .inv_top_left       (inv_top_left),
        .inv_top_right      (inv_top_right),
        .inv_bottom_left    (inv_bottom_left),
        .inv_bottom_right   (inv_bottom_right)
    );

endmodule

// ----- rtl/mim_seq.sv -----
module mim_seq
    import mim_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  stat_t  stat,
    output ctl_t   ctl
);

    logic [PC_W-1:0]       pc_reg;
    logic [PC_W-1:0]       pc_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [BIT_CNT_W-1:0]  bit_cnt_next;
    cw_t                   cw;
    logic                  last;
    logic                  adv;

    // Control word fetch
    assign cw   = ucode_rom(pc_reg);
    assign last = (bit_cnt_reg == BIT_CNT_W'(WORD_BITS - 1));

    // Advance condition
    always_comb
    begin
        unique case (cw.cond)
            COND_ALWAYS:    adv = 1'b1;
            COND_IN_BEAT:   adv = stat.in_beat;
            COND_ITER_LAST: adv = last;
            COND_FOUND:     adv = stat.found;
            COND_OUT_FREE:  adv = stat.out_free;
            default:        adv = 1'b1;
        endcase
    end

    // Next step and bit counter
    always_comb
    begin
        pc_next = pc_reg;
        if (cw.branch && stat.exhausted)
            pc_next = cw.target;
        else if (adv)
            pc_next = cw.jump ? cw.target : pc_reg + PC_W'(1);

        if (cw.cond == COND_ITER_LAST && !adv)
            bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
        else
            bit_cnt_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= PC_START;
            bit_cnt_reg <= '0;
        end
        else
        begin
            pc_reg      <= pc_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    assign ctl.cw      = cw;
    assign ctl.bit_cnt = bit_cnt_reg;
    assign ctl.last    = last;

endmodule

// ----- rtl/mim_dp.sv -----
module mim_dp
    import mim_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctl_t                   ctl,
    output stat_t                  stat,
    input  logic                   cfg_wr_en,
    input  logic [MOD_BITS-1:0]    cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ENTRY_BITS-1:0]  entry_top_left,
    input  logic [ENTRY_BITS-1:0]  entry_top_right,
    input  logic [ENTRY_BITS-1:0]  entry_bottom_left,
    input  logic [ENTRY_BITS-1:0]  entry_bottom_right,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   invertible,
    output logic [WORD_BITS-1:0]   det_residue,
    output logic [WORD_BITS-1:0]   inv_top_left,
    output logic [WORD_BITS-1:0]   inv_top_right,
    output logic [WORD_BITS-1:0]   inv_bottom_left,
    output logic [WORD_BITS-1:0]   inv_bottom_right
);

    logic [MOD_BITS-1:0]   mod_reg;
    logic [MOD_BITS-1:0]   m_eff;

    logic [WORD_BITS-1:0]  a_reg, a_next;
    logic [WORD_BITS-1:0]  b_reg, b_next;
    logic [WORD_BITS-1:0]  c_reg, c_next;
    logic [WORD_BITS-1:0]  d_reg, d_next;
    logic [WORD_BITS-1:0]  det_reg, det_next;
    logic [WORD_BITS-1:0]  k_reg, k_next;
    logic [WORD_BITS-1:0]  t_reg, t_next;
    logic [WORD_BITS-1:0]  acc_reg, acc_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  invertible_reg, invertible_next;
    logic [WORD_BITS-1:0]  det_out_reg, det_out_next;
    logic [WORD_BITS-1:0]  tl_reg, tl_next;
    logic [WORD_BITS-1:0]  tr_reg, tr_next;
    logic [WORD_BITS-1:0]  bl_reg, bl_next;
    logic [WORD_BITS-1:0]  br_reg, br_next;

    logic [WORD_BITS-1:0]  x_val;
    logic [WORD_BITS-1:0]  y_val;
    logic [WORD_BITS-1:0]  acc_in;
    logic [BIT_CNT_W-1:0]  scan_idx;
    logic [MOD_BITS-1:0]   red_t;
    logic [MOD_BITS:0]     mul_t;
    logic [MOD_BITS-1:0]   srch_sum;
    logic [MOD_BITS:0]     sub_t;
    logic [WORD_BITS-1:0]  red_res;
    logic [WORD_BITS-1:0]  mul_res;
    logic [WORD_BITS-1:0]  sub_res;
    logic [WORD_BITS-1:0]  neg_res;
    logic [WORD_BITS-1:0]  srch_res;
    logic                  wr_en;
    logic [WORD_BITS-1:0]  wr_data;
    logic                  out_free;
    logic                  found;
    logic                  at_end;

    // Modulus clamped to its working range
    always_comb
    begin
        if (mod_reg < MOD_MIN)
            m_eff = MOD_MIN;
        else if (mod_reg > MOD_MAX)
            m_eff = MOD_MAX;
        else
            m_eff = mod_reg;
    end

    // Operand selection
    always_comb
    begin
        case (ctl.cw.src_x)
            SEL_A:   x_val = a_reg;
            SEL_B:   x_val = b_reg;
            SEL_C:   x_val = c_reg;
            SEL_D:   x_val = d_reg;
            SEL_DET: x_val = det_reg;
            SEL_K:   x_val = k_reg;
            SEL_T:   x_val = t_reg;
            default: x_val = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.cw.src_y)
            SEL_A:   y_val = a_reg;
            SEL_B:   y_val = b_reg;
            SEL_C:   y_val = c_reg;
            SEL_D:   y_val = d_reg;
            SEL_DET: y_val = det_reg;
            SEL_K:   y_val = k_reg;
            SEL_T:   y_val = t_reg;
            default: y_val = '0;
        endcase
    end

    // Arithmetic unit: one reduction or multiply step per cycle, plus subtract, negate and search add
    always_comb
    begin
        scan_idx = BIT_CNT_W'(WORD_BITS - 1) - ctl.bit_cnt;
        acc_in   = (ctl.bit_cnt == '0) ? '0 : acc_reg;

        // remainder, MSB first: r = 2r + bit
        red_t = {acc_in, x_val[scan_idx]};
        if (red_t >= m_eff)
            red_t = red_t - m_eff;
        red_res = red_t[WORD_BITS-1:0];

        // shift-and-add modular multiply: r = 2r + bit * x, kept below m
        mul_t = {1'b0, acc_in, 1'b0}
              + (y_val[scan_idx] ? {2'b00, x_val} : {(MOD_BITS+1){1'b0}});
        if (mul_t >= {m_eff, 1'b0})
            mul_t = mul_t - {m_eff, 1'b0};
        else if (mul_t >= {1'b0, m_eff})
            mul_t = mul_t - {1'b0, m_eff};
        mul_res = mul_t[WORD_BITS-1:0];

        // difference, wrapped into 0..m-1
        if (x_val >= y_val)
            sub_t = {2'b00, x_val} - {2'b00, y_val};
        else
            sub_t = {2'b00, x_val} + {1'b0, m_eff} - {2'b00, y_val};
        sub_res = sub_t[WORD_BITS-1:0];

        // negation
        neg_res = (x_val == '0) ? '0 : WORD_BITS'(m_eff - {1'b0, x_val});

        // running product det * k for the search
        srch_sum = {1'b0, t_reg} + {1'b0, det_reg};
        if (srch_sum >= m_eff)
            srch_sum = srch_sum - m_eff;
        srch_res = srch_sum[WORD_BITS-1:0];
    end

    // Search and output handshake status
    assign found    = (t_reg == WORD_BITS'(1));
    assign at_end   = ({1'b0, k_reg} == m_eff - MOD_BITS'(1));
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (ctl.cw.op == OP_LOAD);

    assign stat.in_beat   = in_valid && in_ready;
    assign stat.found     = found;
    assign stat.exhausted = (ctl.cw.op == OP_SRCH) && !found && at_end;
    assign stat.out_free  = out_free;

    // Register-file write and special updates
    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        c_next   = c_reg;
        d_next   = d_reg;
        det_next = det_reg;
        k_next   = k_reg;
        t_next   = t_reg;
        acc_next = acc_reg;
        wr_en    = 1'b0;
        wr_data  = '0;

        out_valid_next  = out_valid_reg && !out_ready;
        invertible_next = invertible_reg;
        det_out_next    = det_out_reg;
        tl_next         = tl_reg;
        tr_next         = tr_reg;
        bl_next         = bl_reg;
        br_next         = br_reg;

        unique case (ctl.cw.op)
            OP_LOAD:
            begin
                if (in_valid)
                begin
                    a_next = WORD_BITS'(entry_top_left);
                    b_next = WORD_BITS'(entry_top_right);
                    c_next = WORD_BITS'(entry_bottom_left);
                    d_next = WORD_BITS'(entry_bottom_right);
                end
            end
            OP_RED:
            begin
                acc_next = red_res;
                wr_en    = ctl.last;
                wr_data  = red_res;
            end
            OP_MUL:
            begin
                acc_next = mul_res;
                wr_en    = ctl.last;
                wr_data  = mul_res;
            end
            OP_SUBM:
            begin
                wr_en   = 1'b1;
                wr_data = sub_res;
            end
            OP_NEG:
            begin
                wr_en   = 1'b1;
                wr_data = neg_res;
            end
            OP_SINIT:
            begin
                k_next = WORD_BITS'(1);
                t_next = det_reg;
            end
            OP_SRCH:
            begin
                if (!found && !at_end)
                begin
                    k_next = k_reg + WORD_BITS'(1);
                    t_next = srch_res;
                end
            end
            OP_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    invertible_next = 1'b1;
                    det_out_next    = det_reg;
                    tl_next         = d_reg;
                    tr_next         = b_reg;
                    bl_next         = c_reg;
                    br_next         = a_reg;
                end
            end
            OP_FAIL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    invertible_next = 1'b0;
                    det_out_next    = det_reg;
                    tl_next         = '0;
                    tr_next         = '0;
                    bl_next         = '0;
                    br_next         = '0;
                end
            end
            default:
            begin
            end
        endcase

        if (wr_en)
        begin
            case (ctl.cw.dst)
                SEL_A:   a_next   = wr_data;
                SEL_B:   b_next   = wr_data;
                SEL_C:   c_next   = wr_data;
                SEL_D:   d_next   = wr_data;
                SEL_DET: det_next = wr_data;
                SEL_K:   k_next   = wr_data;
                SEL_T:   t_next   = wr_data;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg       <= MOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mod_reg <= cfg_wr_data;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        c_reg          <= c_next;
        d_reg          <= d_next;
        det_reg        <= det_next;
        k_reg          <= k_next;
        t_reg          <= t_next;
        acc_reg        <= acc_next;
        invertible_reg <= invertible_next;
        det_out_reg    <= det_out_next;
        tl_reg         <= tl_next;
        tr_reg         <= tr_next;
        bl_reg         <= bl_next;
        br_reg         <= br_next;
    end

    assign out_valid        = out_valid_reg;
    assign invertible       = invertible_reg;
    assign det_residue      = det_out_reg;
    assign inv_top_left     = tl_reg;
    assign inv_top_right    = tr_reg;
    assign inv_bottom_left  = bl_reg;
    assign inv_bottom_right = br_reg;

endmodule
